// ===== sv/stick_to_dpad_with_auto_repeat_unit_defines.svh =====
// assertion macros for the stick to d-pad unit
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef STICK_TO_DPAD_WITH_AUTO_REPEAT_UNIT_DEFINES_SVH
`define STICK_TO_DPAD_WITH_AUTO_REPEAT_UNIT_DEFINES_SVH

// same-cycle implication
`define STDAR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stdar assertion failed");

// next-cycle implication
`define STDAR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stdar assertion failed");

`endif

// ===== sv/stdar_pkg.sv =====
// shared types and constants for the stick to d-pad unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stdar_pkg;

    localparam int DIR_LSB = 4;

    localparam logic [6:0] DEAD_ZONE_RST    = 7'd64;
    localparam logic [7:0] FIRST_DELAY_RST  = 8'd15;
    localparam logic [7:0] REPEAT_DELAY_RST = 8'd6;
    localparam logic [7:0] FAST_AFTER_RST   = 8'd30;
    localparam logic [7:0] FAST_DELAY_RST   = 8'd1;
    localparam logic [7:0] COUNT_MAX        = 8'd255;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_NEG  = 2'd1,
        DIR_POS  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        CFG_DEAD_ZONE    = 3'd0,
        CFG_FIRST_DELAY  = 3'd1,
        CFG_REPEAT_DELAY = 3'd2,
        CFG_FAST_AFTER   = 3'd3,
        CFG_FAST_DELAY   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [6:0] dead_zone;
        logic [7:0] first_delay;
        logic [7:0] repeat_delay;
        logic [7:0] fast_after;
        logic [7:0] fast_delay;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic              has_stick;
        logic [15:0]       held_in;
        logic [15:0]       pressed_in;
    } t_in_item;

endpackage

`default_nettype wire

// ===== sv/stdar_ifs.sv =====
// valid/ready channel interfaces: input beat, result beat, config write
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface stdar_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
    logic              has_stick;
    logic [15:0]       held_in;
    logic [15:0]       pressed_in;

    modport source (output valid, stick_x, stick_y, has_stick, held_in, pressed_in,
                    input ready);
    modport sink (input valid, stick_x, stick_y, has_stick, held_in, pressed_in,
                  output ready);
endinterface

interface stdar_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] held_out;
    logic [15:0] pressed_out;

    modport source (output valid, held_out, pressed_out, input ready);
    modport sink (input valid, held_out, pressed_out, output ready);
endinterface

interface stdar_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/stdar_axis.sv =====
// one stick axis against the dead zone: held bits, entry edges, new direction
// depends on stdar_pkg
`timescale 1ns / 1ps
`default_nettype none

module stdar_axis (
    input  wire logic signed [7:0] i_v,
    input  wire logic [6:0]        i_dead_zone,
    input  stdar_pkg::t_dir        i_last,
    output stdar_pkg::t_dir        o_dir,
    output logic [1:0]             o_held,
    output logic [1:0]             o_edge
);
    import stdar_pkg::*;

    logic signed [8:0] v9;
    logic signed [8:0] dz9;
    logic              neg;
    logic              pos;

    assign v9  = {i_v[7], i_v};
    assign dz9 = $signed({2'b00, i_dead_zone});
    assign neg = v9 < -dz9;
    assign pos = v9 > dz9;

    // bit 0 negative direction, bit 1 positive direction
    always_comb begin
        o_held = 2'b00;
        o_edge = 2'b00;
        o_dir  = DIR_NONE;
        if (neg) begin
            o_held[0] = 1'b1;
            o_edge[0] = (i_last != DIR_NEG);
            o_dir     = DIR_NEG;
        end else if (pos) begin
            o_held[1] = 1'b1;
            o_edge[1] = (i_last != DIR_POS);
            o_dir     = DIR_POS;
        end
    end

endmodule

`default_nettype wire

// ===== sv/stdar_repeat.sv =====
// direction auto-repeat: first delay, repeat delay, fast delay after a hold count
// depends on stdar_pkg
`timescale 1ns / 1ps
`default_nettype none

module stdar_repeat (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [3:0]       i_dirs,
    input  stdar_pkg::t_cfg       i_cfg,
    output logic [3:0]            o_press
);
    import stdar_pkg::*;

    typedef enum logic {
        RPT_IDLE,
        RPT_ACTIVE
    } t_rpt_state;

    t_rpt_state r_state, n_state;
    logic [7:0] r_count, n_count;
    logic [7:0] r_delay, n_delay;
    logic [7:0] r_hold,  n_hold;
    logic [7:0] count_inc;
    logic [7:0] hold_inc;
    logic       any_dir;
    logic       fire;

    assign any_dir   = |i_dirs;
    assign count_inc = (r_count < COUNT_MAX) ? r_count + 8'd1 : r_count;
    assign hold_inc  = (r_hold < i_cfg.fast_after) ? r_hold + 8'd1 : r_hold;
    assign fire      = (r_delay <= count_inc);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_delay = r_delay;
        n_hold  = r_hold;
        o_press = 4'b0000;
        case (r_state)
            RPT_IDLE: begin
                if (any_dir) begin
                    n_state = RPT_ACTIVE;
                    n_count = 8'd0;
                    n_delay = i_cfg.first_delay;
                    n_hold  = 8'd0;
                end
            end
            RPT_ACTIVE: begin
                if (!any_dir) begin
                    n_state = RPT_IDLE;
                end else begin
                    n_count = count_inc;
                    n_hold  = hold_inc;
                    if (fire) begin
                        n_count = 8'd0;
                        n_delay = i_cfg.repeat_delay;
                        o_press = i_dirs;
                    end
                    if (hold_inc >= i_cfg.fast_after) begin
                        n_delay = i_cfg.fast_delay;
                    end
                end
            end
            default: begin
                n_state = RPT_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RPT_IDLE;
            r_count <= 8'd0;
            r_delay <= 8'd0;
            r_hold  <= 8'd0;
        end else if (i_step) begin
            r_state <= n_state;
            r_count <= n_count;
            r_delay <= n_delay;
            r_hold  <= n_hold;
        end
    end

endmodule

`default_nettype wire

// ===== sv/stick_to_dpad_with_auto_repeat_unit.sv =====
// Stick to d-pad unit with direction auto-repeat.
// Channels: i_in carries one beat per frame tick (stick x/y, has_stick, held and
// pressed masks); o_out returns one beat per input beat (merged held mask,
// pressed mask with stick edges and repeated presses); i_cfg writes the five
// registers (0 dead zone, 1 first delay, 2 repeat delay, 3 fast after,
// 4 fast delay), other indexes are ignored. i_cfg is always ready.
// Accepted beats pass the input register and then the result register (o_out).
// Throughput: one beat per cycle while o_out takes results, set by the input
// register, the single digitize/repeat pass and the result register.
// Reset (synchronous, active low) empties both registers, restores the
// register defaults and clears the last directions and repeat state.
// When o_out stalls the result holds; one more beat is taken into the input
// register, then i_in.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "stick_to_dpad_with_auto_repeat_unit_defines.svh"

module stick_to_dpad_with_auto_repeat_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    stdar_in_if.sink      i_in,
    stdar_out_if.source   o_out,
    stdar_cfg_if.sink     i_cfg
);
    import stdar_pkg::*;

    t_cfg        r_cfg;
    t_in_item    r_in;
    logic        r_in_valid;
    logic        r_out_valid;
    logic [15:0] r_held_out;
    logic [15:0] r_pressed_out;
    t_dir        r_x_last;
    t_dir        r_y_last;

    logic        advance;
    logic        in_ready;
    logic        step;
    t_dir        x_dir;
    t_dir        y_dir;
    logic [1:0]  x_held;
    logic [1:0]  x_edge;
    logic [1:0]  y_held;
    logic [1:0]  y_edge;
    logic [3:0]  stick_held;
    logic [3:0]  stick_edge;
    logic [3:0]  dirs;
    logic [3:0]  rpt_press;
    logic [15:0] n_held;
    logic [15:0] n_pressed;

    assign advance  = !r_out_valid || o_out.ready;
    assign in_ready = !r_in_valid || advance;
    assign step     = r_in_valid && advance;

    assign i_in.ready        = in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.held_out    = r_held_out;
    assign o_out.pressed_out = r_pressed_out;

    stdar_axis u_axis_x (
        .i_v         (r_in.stick_x),
        .i_dead_zone (r_cfg.dead_zone),
        .i_last      (r_x_last),
        .o_dir       (x_dir),
        .o_held      (x_held),
        .o_edge      (x_edge)
    );

    stdar_axis u_axis_y (
        .i_v         (r_in.stick_y),
        .i_dead_zone (r_cfg.dead_zone),
        .i_last      (r_y_last),
        .o_dir       (y_dir),
        .o_held      (y_held),
        .o_edge      (y_edge)
    );

    // order: up, down, left, right
    assign stick_held = r_in.has_stick ? {x_held, y_held} : 4'b0000;
    assign stick_edge = r_in.has_stick ? {x_edge, y_edge} : 4'b0000;

    always_comb begin
        n_held = r_in.held_in;
        n_held[DIR_LSB +: 4] = r_in.held_in[DIR_LSB +: 4] | stick_held;
    end

    assign dirs = n_held[DIR_LSB +: 4];

    stdar_repeat u_repeat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_dirs  (dirs),
        .i_cfg   (r_cfg),
        .o_press (rpt_press)
    );

    always_comb begin
        n_pressed = r_in.pressed_in;
        n_pressed[DIR_LSB +: 4] = r_in.pressed_in[DIR_LSB +: 4] | stick_edge | rpt_press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone    <= DEAD_ZONE_RST;
            r_cfg.first_delay  <= FIRST_DELAY_RST;
            r_cfg.repeat_delay <= REPEAT_DELAY_RST;
            r_cfg.fast_after   <= FAST_AFTER_RST;
            r_cfg.fast_delay   <= FAST_DELAY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEAD_ZONE:    r_cfg.dead_zone    <= i_cfg.data[6:0];
                CFG_FIRST_DELAY:  r_cfg.first_delay  <= i_cfg.data;
                CFG_REPEAT_DELAY: r_cfg.repeat_delay <= i_cfg.data;
                CFG_FAST_AFTER:   r_cfg.fast_after   <= i_cfg.data;
                CFG_FAST_DELAY:   r_cfg.fast_delay   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in.stick_x    <= i_in.stick_x;
            r_in.stick_y    <= i_in.stick_y;
            r_in.has_stick  <= i_in.has_stick;
            r_in.held_in    <= i_in.held_in;
            r_in.pressed_in <= i_in.pressed_in;
        end
    end

    // last directions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_last <= DIR_NONE;
            r_y_last <= DIR_NONE;
        end else if (step && r_in.has_stick) begin
            r_x_last <= x_dir;
            r_y_last <= y_dir;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_held_out    <= n_held;
            r_pressed_out <= n_pressed;
        end
    end

    `STDAR_ASSERT_NEXT(a_step_loads_result, step, r_out_valid)
    `STDAR_ASSERT_NOW(a_stall_means_full, !in_ready, r_in_valid && r_out_valid)
    `STDAR_ASSERT_NOW(a_axis_one_way, step, $onehot0(x_held) && $onehot0(y_held))

endmodule

`default_nettype wire
